// File: hdl/aspc_pkg.sv
// ----------------------------------------------------------------------------
// aspc_pkg
// Shared types and constants of the arc sector point classifier: register
// indexes, class codes, configuration and geometry bundles, stage payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package aspc_pkg;

  // fixed field widths
  localparam int unsigned CoordW   = 32;
  localparam int unsigned TrigW    = 18;
  localparam int unsigned WidthW   = 31;
  localparam int unsigned TrigFrac = 16;
  localparam int unsigned CenterW  = 34;
  localparam int unsigned SquareW  = 64;
  localparam int unsigned CfgIdxW  = 3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ROT_COS    = 3'd0,
    REG_ROT_SIN    = 3'd1,
    REG_DOWN_SHIFT = 3'd2,
    REG_SECT_WIDTH = 3'd3,
    REG_RADIUS_A   = 3'd4,
    REG_RADIUS_B   = 3'd5
  } cfg_reg_e;

  // region class codes
  typedef enum logic [1:0] {
    CLASS_WRONG_SIDE = 2'd0,
    CLASS_BELOW      = 2'd1,
    CLASS_INSIDE     = 2'd2,
    CLASS_BEYOND     = 2'd3
  } region_class_e;

  // rotation and shift settings
  typedef struct packed {
    logic signed [TrigW-1:0]  rot_cos;
    logic signed [TrigW-1:0]  rot_sin;
    logic signed [CoordW-1:0] down_shift;
  } rot_cfg_t;

  // derived sector geometry
  typedef struct packed {
    logic signed [CenterW-1:0] inner_center_y;
    logic signed [CenterW-1:0] outer_center_y;
    logic [SquareW-1:0]        inner_radius_squared;
    logic [SquareW-1:0]        outer_radius_squared;
    logic                      sign_change;
  } geom_t;

  // squared distance terms of one point
  typedef struct packed {
    logic               wrong_side;
    logic               sat_x;
    logic               sat_in;
    logic               sat_out;
    logic [SquareW-1:0] dx2;
    logic [SquareW-1:0] dy_in2;
    logic [SquareW-1:0] dy_out2;
  } dist_t;

endpackage

`default_nettype wire

// File: hdl/aspc_cfg.sv
// ----------------------------------------------------------------------------
// aspc_cfg
// Configuration registers and the two-stage derivation of the sector
// geometry: radius ordering and circle centres, then squared radii.
// ----------------------------------------------------------------------------
`default_nettype none

module aspc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [aspc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [aspc_pkg::CoordW-1:0]   cfg_data_i,
  output aspc_pkg::rot_cfg_t                 rot_o,
  output aspc_pkg::geom_t                    geom_o
);

  aspc_pkg::rot_cfg_t              rot_q;
  logic [aspc_pkg::WidthW-1:0]     width_q;
  logic signed [aspc_pkg::CoordW-1:0] rad_a_q, rad_b_q;

  logic signed [aspc_pkg::CenterW-1:0] ic_d, ic_q, oc_d, oc_q;
  logic                                sc_d, sc_q;
  logic [aspc_pkg::CoordW-1:0]         mag_in_d, mag_in_q, mag_out_d, mag_out_q;
  logic [aspc_pkg::SquareW-1:0]        r2_in_d, r2_in_q, r2_out_d, r2_out_q;

  logic signed [aspc_pkg::CoordW-1:0]  inner_sel, outer_sel, inner, outer;
  logic signed [aspc_pkg::CenterW-1:0] inner_ext, outer_ext, width_ext;
  logic                                both_neg, inner_pos, outer_pos;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q.rot_cos    <= 18'sd65536;
      rot_q.rot_sin    <= '0;
      rot_q.down_shift <= '0;
      width_q          <= '0;
      rad_a_q          <= '0;
      rad_b_q          <= '0;
    end else if (cfg_valid_i) begin
      case (aspc_pkg::cfg_reg_e'(cfg_index_i))
        aspc_pkg::REG_ROT_COS:    rot_q.rot_cos    <= cfg_data_i[aspc_pkg::TrigW-1:0];
        aspc_pkg::REG_ROT_SIN:    rot_q.rot_sin    <= cfg_data_i[aspc_pkg::TrigW-1:0];
        aspc_pkg::REG_DOWN_SHIFT: rot_q.down_shift <= cfg_data_i;
        aspc_pkg::REG_SECT_WIDTH: width_q          <= cfg_data_i[aspc_pkg::WidthW-1:0];
        aspc_pkg::REG_RADIUS_A:   rad_a_q          <= cfg_data_i;
        aspc_pkg::REG_RADIUS_B:   rad_b_q          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // order the radii, swap when both negative, place the centres
  always_comb begin
    inner_sel = (rad_a_q < rad_b_q) ? rad_a_q : rad_b_q;
    outer_sel = (rad_a_q < rad_b_q) ? rad_b_q : rad_a_q;
    both_neg  = inner_sel[aspc_pkg::CoordW-1] & outer_sel[aspc_pkg::CoordW-1];
    inner     = both_neg ? outer_sel : inner_sel;
    outer     = both_neg ? inner_sel : outer_sel;
    inner_ext = {{2{inner[aspc_pkg::CoordW-1]}}, inner};
    outer_ext = {{2{outer[aspc_pkg::CoordW-1]}}, outer};
    width_ext = {3'b000, width_q};
    inner_pos = !inner[aspc_pkg::CoordW-1] && (inner != '0);
    outer_pos = !outer[aspc_pkg::CoordW-1] && (outer != '0);
    sc_d      = inner[aspc_pkg::CoordW-1] && outer_pos;
    ic_d      = inner_pos ? (inner_ext + width_ext) : (inner_ext - width_ext);
    // with a sign change the outer centre is the outer radius plus the width
    oc_d      = (sc_d || !outer_pos) ? (outer_ext + width_ext) : (outer_ext - width_ext);
    mag_in_d  = inner[aspc_pkg::CoordW-1] ? (~inner + 32'd1) : inner;
    mag_out_d = outer[aspc_pkg::CoordW-1] ? (~outer + 32'd1) : outer;
  end

  // squared radii from the registered magnitudes
  always_comb begin
    r2_in_d  = mag_in_q * mag_in_q;
    r2_out_d = mag_out_q * mag_out_q;
  end

  // derived geometry, two register stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q      <= '0;
      oc_q      <= '0;
      sc_q      <= 1'b0;
      mag_in_q  <= '0;
      mag_out_q <= '0;
      r2_in_q   <= '0;
      r2_out_q  <= '0;
    end else begin
      ic_q      <= ic_d;
      oc_q      <= oc_d;
      sc_q      <= sc_d;
      mag_in_q  <= mag_in_d;
      mag_out_q <= mag_out_d;
      r2_in_q   <= r2_in_d;
      r2_out_q  <= r2_out_d;
    end
  end

  assign rot_o                       = rot_q;
  assign geom_o.inner_center_y       = ic_q;
  assign geom_o.outer_center_y       = oc_q;
  assign geom_o.inner_radius_squared = r2_in_q;
  assign geom_o.outer_radius_squared = r2_out_q;
  assign geom_o.sign_change          = sc_q;

endmodule

`default_nettype wire

// File: hdl/aspc_rotate.sv
// ----------------------------------------------------------------------------
// aspc_rotate
// Rotation of a point: four products in the first stage, then sums with
// floor shift and the x offset in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module aspc_rotate (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic signed [aspc_pkg::CoordW-1:0] point_x_i,
  input  wire logic signed [aspc_pkg::CoordW-1:0] point_y_i,
  input  aspc_pkg::rot_cfg_t                     rot_i,
  output logic                                   valid_o,
  output logic signed [35:0]                     xr_o,
  output logic signed [34:0]                     yr_o
);

  logic signed [49:0] pxc_d, pxc_q, pys_d, pys_q, pxs_d, pxs_q, pyc_d, pyc_q;
  logic signed [50:0] sum_x, sum_y;
  logic signed [35:0] xr_d, xr_q;
  logic signed [34:0] yr_d, yr_q;
  logic               v1_q, v2_q;

  // products
  always_comb begin
    pxc_d = point_x_i * rot_i.rot_cos;
    pys_d = point_y_i * rot_i.rot_sin;
    pxs_d = point_x_i * rot_i.rot_sin;
    pyc_d = point_y_i * rot_i.rot_cos;
  end

  // sums, floor shift by the trig fraction, x offset
  always_comb begin
    sum_x = {pxc_q[49], pxc_q} - {pys_q[49], pys_q};
    sum_y = {pxs_q[49], pxs_q} + {pyc_q[49], pyc_q};
    xr_d  = {sum_x[50], sum_x[50:aspc_pkg::TrigFrac]}
          + {{4{rot_i.down_shift[aspc_pkg::CoordW-1]}}, rot_i.down_shift};
    yr_d  = sum_y[50:aspc_pkg::TrigFrac];
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxc_q <= pxc_d;
      pys_q <= pys_d;
      pxs_q <= pxs_d;
      pyc_q <= pyc_d;
      xr_q  <= xr_d;
      yr_q  <= yr_d;
    end
  end

  assign valid_o = v2_q;
  assign xr_o    = xr_q;
  assign yr_o    = yr_q;

endmodule

`default_nettype wire

// File: hdl/aspc_distance.sv
// ----------------------------------------------------------------------------
// aspc_distance
// Offsets to both circle centres with magnitude and saturation flags, then
// the three squares side by side, each step in a stage of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module aspc_distance (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic signed [35:0]   xr_i,
  input  wire logic signed [34:0]   yr_i,
  input  aspc_pkg::geom_t           geom_i,
  output logic                      valid_o,
  output aspc_pkg::dist_t           dist_o
);

  logic signed [35:0] dy_in, dy_out;
  logic [35:0]        mag_x, mag_in, mag_out;
  logic               neg_d, neg_q;
  logic               sx_d, sx_q, si_d, si_q, so_d, so_q;
  logic [31:0]        mx_d, mx_q, mi_d, mi_q, mo_d, mo_q;
  logic               v3_q, v4_q;
  aspc_pkg::dist_t    dist_d, dist_q;

  function automatic logic [35:0] abs36(input logic [35:0] v);
    return v[35] ? (~v + 36'd1) : v;
  endfunction

  // offsets and magnitudes, anything from 2^32 up saturates its square
  always_comb begin
    dy_in   = {yr_i[34], yr_i} - {{2{geom_i.inner_center_y[33]}}, geom_i.inner_center_y};
    dy_out  = {yr_i[34], yr_i} - {{2{geom_i.outer_center_y[33]}}, geom_i.outer_center_y};
    mag_x   = abs36(xr_i);
    mag_in  = abs36(dy_in);
    mag_out = abs36(dy_out);
    neg_d   = xr_i[35];
    sx_d    = |mag_x[35:32];
    si_d    = |mag_in[35:32];
    so_d    = |mag_out[35:32];
    mx_d    = mag_x[31:0];
    mi_d    = mag_in[31:0];
    mo_d    = mag_out[31:0];
  end

  // squares
  always_comb begin
    dist_d.wrong_side = neg_q;
    dist_d.sat_x      = sx_q;
    dist_d.sat_in     = si_q;
    dist_d.sat_out    = so_q;
    dist_d.dx2        = mx_q * mx_q;
    dist_d.dy_in2     = mi_q * mi_q;
    dist_d.dy_out2    = mo_q * mo_q;
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q  <= neg_d;
      sx_q   <= sx_d;
      si_q   <= si_d;
      so_q   <= so_d;
      mx_q   <= mx_d;
      mi_q   <= mi_d;
      mo_q   <= mo_d;
      dist_q <= dist_d;
    end
  end

  assign valid_o = v4_q;
  assign dist_o  = dist_q;

endmodule

`default_nettype wire

// File: hdl/aspc_classify.sv
// ----------------------------------------------------------------------------
// aspc_classify
// Saturating distance sums, comparison against the squared radii and the
// region decision, held in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aspc_classify (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  aspc_pkg::dist_t  dist_i,
  input  aspc_pkg::geom_t  geom_i,
  output logic             valid_o,
  output logic [1:0]       region_class_o
);

  logic [64:0]                   sum_in, sum_out;
  logic                          sat_in, sat_out, over_inner, under_outer, in_region;
  aspc_pkg::region_class_e       class_d, class_q;
  logic                          v5_q;

  // distance tests, a saturated sum is beyond any squared radius
  always_comb begin
    sum_in      = {1'b0, dist_i.dx2} + {1'b0, dist_i.dy_in2};
    sum_out     = {1'b0, dist_i.dx2} + {1'b0, dist_i.dy_out2};
    sat_in      = dist_i.sat_x | dist_i.sat_in | sum_in[64];
    sat_out     = dist_i.sat_x | dist_i.sat_out | sum_out[64];
    over_inner  = sat_in | (sum_in[63:0] >= geom_i.inner_radius_squared);
    under_outer = !sat_out && (sum_out[63:0] <= geom_i.outer_radius_squared);
    // sign change inverts the outer test
    in_region   = geom_i.sign_change ? (over_inner && !under_outer)
                                     : (over_inner && under_outer);
    if (dist_i.wrong_side) begin
      class_d = aspc_pkg::CLASS_WRONG_SIDE;
    end else if (in_region) begin
      class_d = aspc_pkg::CLASS_INSIDE;
    end else if (!over_inner) begin
      class_d = aspc_pkg::CLASS_BELOW;
    end else begin
      class_d = aspc_pkg::CLASS_BEYOND;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      class_q <= class_d;
    end
  end

  assign valid_o        = v5_q;
  assign region_class_o = class_q;

endmodule

`default_nettype wire

// File: hdl/arc_sector_point_classifier.sv
// ----------------------------------------------------------------------------
// arc_sector_point_classifier
// Rotates and shifts each hit point and classifies it against a sector
// bounded by two signed-radius arcs, using squared-distance comparisons.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                payload
//   -------  ---------  -----------------------  --------------------------
//   cfg      in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in         in_valid_i/in_ready_o    point_x_i, point_y_i
//   out      out        out_valid_o/out_ready_i  region_class_o
//
// one point enters per clock while no result is held back at the output; each
// result passes through the five register stages (products, rotation,
// offsets, squares, decision) before it is valid
// a stalled output freezes the whole pipeline, so nothing is lost or repeated
// a register write updates the circle centres first and the squared radii after them
// reset is asynchronous and active low and restores the default settings
// ----------------------------------------------------------------------------
`default_nettype none

module arc_sector_point_classifier (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [aspc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [aspc_pkg::CoordW-1:0]        cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [aspc_pkg::CoordW-1:0] point_x_i,
  input  wire logic signed [aspc_pkg::CoordW-1:0] point_y_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [1:0]                              region_class_o
);

  aspc_pkg::rot_cfg_t rot;
  aspc_pkg::geom_t    geom;
  aspc_pkg::dist_t    dist_terms;
  logic               en;
  logic               rot_valid, dist_valid;
  logic signed [35:0] xr;
  logic signed [34:0] yr;

  // pipeline advances unless a result is held back
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  aspc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rot_o       (rot),
    .geom_o      (geom)
  );

  aspc_rotate u_rotate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .rot_i     (rot),
    .valid_o   (rot_valid),
    .xr_o      (xr),
    .yr_o      (yr)
  );

  aspc_distance u_distance (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rot_valid),
    .xr_i    (xr),
    .yr_i    (yr),
    .geom_i  (geom),
    .valid_o (dist_valid),
    .dist_o  (dist_terms)
  );

  aspc_classify u_classify (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (dist_valid),
    .dist_i         (dist_terms),
    .geom_i         (geom),
    .valid_o        (out_valid_o),
    .region_class_o (region_class_o)
  );

endmodule

`default_nettype wire
